// ----- hw/rtl/hsv_brightness_adjust_core_assert.svh -----
// Assertion macros shared by the brightness adjust RTL.
// Included by modules that check their own pipeline behavior.
`ifndef HSV_BRIGHTNESS_ADJUST_CORE_ASSERT_SVH
`define HSV_BRIGHTNESS_ADJUST_CORE_ASSERT_SVH
// property that must hold while out of reset
`define HBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define HBA_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

// ----- hw/rtl/hba_pkg.sv -----
// Package for the brightness adjust block: payload types and constants.
// Used by the core RTL file of the block.
package hba_pkg;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [6:0] percent;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;
endpackage

// ----- hw/rtl/hsv_brightness_adjust_core.sv -----
// Brightness adjust core: RGB pixel in, value replaced by a percent, RGB out.
// Channels: in_* (pix_in_t payload) and out_* (pix_out_t payload), each
// with valid and ready; a beat moves when valid and ready are both high.
// Stages: min/max and sector offsets; two pipelined dividers (saturation
// and hue, one quotient bit per stage); hue sector and fraction; two
// products S*f; scale numerators; division by 100*2^F as a shift and a
// reciprocal multiply; channel select.
// Latency is set by the hue divider depth plus six register stages.
// Throughput is one pixel per cycle unless the receiver stalls;
// the pipeline length sets the latency.
// The whole pipe advances as one when the output stage is empty or taken,
// so a stalled receiver freezes every stage and no beat is lost or doubled;
// in_ready follows the same enable, and a new pixel is taken while a
// finished result waits in the output register only if that moves too.
// Reset clears all valid bits; payload registers keep no reset value.
// Grey input (max equal to min) yields percent*255/100 on every channel.
// Percent is clamped to 1..100 before use.
module hsv_brightness_adjust_core #(
    parameter int FRAC_BITS = hba_pkg::FRAC_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hba_pkg::pix_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hba_pkg::pix_out_t out_data
);
    import hba_pkg::*;
    `include "hsv_brightness_adjust_core_assert.svh"

    localparam int F = FRAC_BITS;
    localparam int SN_W = 8 + F;
    localparam int HN_W = 11 + F;
    localparam int SC_NUM_W = 15 + F;
    localparam int RCP = 5243;
    localparam int RCP_SH = 19;

    typedef struct packed {
        logic [6:0] p;
        logic       grey;
        logic [7:0] n;
        logic [7:0] d;
    } st1_t;

    logic en;
    assign en = !out_valid || out_ready;
    assign in_ready = en;

    // stage 1: max, min, sector offset
    st1_t s1_reg, s1_next;
    logic s1_vld_reg;
    logic [7:0] r, g, b, mx, mn, dl;
    logic [10:0] nn;
    logic [6:0] pc;
    always_comb
    begin
        r = in_data.red_in;
        g = in_data.green_in;
        b = in_data.blue_in;
        pc = in_data.percent;
        if (pc == 7'd0)
            pc = 7'd1;
        else if (pc > 7'd100)
            pc = 7'd100;
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        mn = r;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        dl = mx - mn;
        if (r == mx)
            nn = (g >= b) ? 11'(g - b) : 11'(11'(6 * dl) - 11'(b - g));
        else if (g == mx)
            nn = 11'(11'(2 * dl) + 11'(b) - 11'(r));
        else
            nn = 11'(11'(4 * dl) + 11'(r) - 11'(g));
        s1_next.p = pc;
        s1_next.grey = (dl == 8'd0);
        s1_next.n = mx;
        s1_next.d = dl;
    end

    logic [10:0] hn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_next;
            hn_reg <= nn;
        end
    end

    // saturation divider: delta*2^F / max (carries delta and p along)
    logic sdv_vld, hdv_vld;
    logic [SN_W-1:0] s_q;
    logic [HN_W-1:0] h_q;
    logic [15:0] s_side;
    logic [15:0] h_side;
    logic [10:0] six_d;
    assign six_d = 11'(6 * s1_reg.d);

    hba_div #(.NUM_W(SN_W), .DEN_W(8), .SIDE_W(16)) u_sdiv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s1_vld_reg),
        .num({s1_reg.d, {F{1'b0}}}),
        .den(s1_reg.grey ? 8'd1 : s1_reg.n),
        .side_in({s1_reg.grey, s1_reg.p, s1_reg.d}),
        .out_vld(sdv_vld), .quo(s_q), .side_out(s_side)
    );
    hba_div #(.NUM_W(HN_W), .DEN_W(11), .SIDE_W(16)) u_hdiv (
        .clk(clk), .rst_n(rst_n), .en(en), .in_vld(s1_vld_reg),
        .num({hn_reg, {F{1'b0}}}),
        .den(s1_reg.grey ? 11'd1 : six_d),
        .side_in({s1_reg.grey, s1_reg.p, s1_reg.d}),
        .out_vld(hdv_vld), .quo(h_q), .side_out(h_side)
    );

    // hue divider is three stages longer; delay saturation side to match
    localparam int LAG = HN_W - SN_W;
    logic [SN_W-1:0] sq_d [LAG+1];
    logic [15:0] ss_d [LAG+1];
    logic [LAG:0] sv_d;
    assign sq_d[0] = s_q;
    assign ss_d[0] = s_side;
    assign sv_d[0] = sdv_vld;
    for (genvar i = 0; i < LAG; i++)
    begin : g_lag
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sv_d[i+1] <= 1'b0;
            else if (en)
                sv_d[i+1] <= sv_d[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_d[i+1] <= sq_d[i];
                ss_d[i+1] <= ss_d[i];
            end
        end
    end

    // stage: sector and fraction
    logic [F:0]   s3_s_reg;
    logic [F-1:0] s3_f_reg;
    logic [2:0]   s3_k_reg;
    logic [6:0]   s3_p_reg;
    logic         s3_grey_reg, s3_vld_reg;
    logic [F-1:0] hc;
    logic [F+2:0] h6;
    always_comb
    begin
        hc = (h_q > HN_W'({F{1'b1}})) ? {F{1'b1}} : h_q[F-1:0];
        h6 = (F+3)'(hc) * (F+3)'(6);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= hdv_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_s_reg <= sq_d[LAG][F:0];
            s3_f_reg <= h6[F-1:0];
            s3_k_reg <= h6[F+2:F];
            s3_p_reg <= ss_d[LAG][14:8];
            s3_grey_reg <= ss_d[LAG][15];
        end
    end

    // stage: products S*f and S*(2^F-f)
    logic [F:0]   s4_lo_reg, s4_rise_reg;
    logic [F-1:0] s4_fall_reg;
    logic [2:0]   s4_k_reg;
    logic [6:0]   s4_p_reg;
    logic         s4_grey_reg, s4_vld_reg;
    logic [2*F:0] pf, pr;
    assign pf = (2*F+1)'(s3_s_reg) * (2*F+1)'(s3_f_reg);
    assign pr = (2*F+1)'(s3_s_reg) * (2*F+1)'(((F+1)'(1) << F) - (F+1)'(s3_f_reg));
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= s3_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_lo_reg <= s3_s_reg;
            s4_fall_reg <= pf[2*F-1:F];
            s4_rise_reg <= pr[2*F:F];
            s4_k_reg <= s3_k_reg;
            s4_p_reg <= s3_p_reg;
            s4_grey_reg <= s3_grey_reg;
        end
    end

    // stage: scale numerators p*255*(2^F - t)
    logic [SC_NUM_W-1:0] s5_num_reg [4];
    logic [2:0] s5_k_reg;
    logic       s5_grey_reg, s5_vld_reg;
    logic [14:0] p255;
    logic [F:0] tt [4];
    assign p255 = 15'(s4_p_reg * 8'd255);
    assign tt[0] = '0;
    assign tt[1] = s4_grey_reg ? '0 : s4_lo_reg;
    assign tt[2] = s4_grey_reg ? '0 : {1'b0, s4_fall_reg};
    assign tt[3] = s4_grey_reg ? '0 : s4_rise_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (en)
            s5_vld_reg <= s4_vld_reg;
    end
    for (genvar c = 0; c < 4; c++)
    begin : g_num
        always_ff @(posedge clk)
        begin
            if (en)
                s5_num_reg[c] <= SC_NUM_W'(SC_NUM_W'(p255)
                    * SC_NUM_W'(((F+1)'(1) << F) - tt[c]));
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_k_reg <= s4_k_reg;
            s5_grey_reg <= s4_grey_reg;
        end
    end

    // stage: divide by 100*2^F, drop the fraction then multiply by 2^19/100
    logic [7:0] s6_q_reg [4];
    logic [2:0] s6_k_reg;
    logic       s6_grey_reg, s6_vld_reg;
    logic [27:0] rq [4];
    for (genvar c = 0; c < 4; c++)
    begin : g_sc
        assign rq[c] = 28'(s5_num_reg[c][SC_NUM_W-1:F]) * 28'(RCP);
        always_ff @(posedge clk)
        begin
            if (en)
                s6_q_reg[c] <= rq[c][RCP_SH+7:RCP_SH];
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_vld_reg <= 1'b0;
        else if (en)
            s6_vld_reg <= s5_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_k_reg <= s5_k_reg;
            s6_grey_reg <= s5_grey_reg;
        end
    end

    // output register with sector select
    pix_out_t out_reg, out_next;
    logic out_vld_reg;
    logic [7:0] top, lo, fa, ri;
    always_comb
    begin
        top = s6_q_reg[0];
        lo = s6_q_reg[1];
        fa = s6_q_reg[2];
        ri = s6_q_reg[3];
        if (s6_grey_reg)
            out_next = '{top, top, top};
        else
        begin
            case (s6_k_reg)
                3'd0: out_next = '{top, ri, lo};
                3'd1: out_next = '{fa, top, lo};
                3'd2: out_next = '{lo, top, ri};
                3'd3: out_next = '{lo, fa, top};
                3'd4: out_next = '{ri, lo, top};
                default: out_next = '{top, lo, fa};
            endcase
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= s6_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end
    assign out_valid = out_vld_reg;
    assign out_data = out_reg;

    `HBA_ASSERT(a_ready_en, clk, rst_n, in_ready == (!out_valid || out_ready),
        "in_ready out of step with output stall")
    `HBA_ASSERT(a_div_align, clk, rst_n, sv_d[LAG] == hdv_vld,
        "divider valid bits out of step")
    `HBA_ASSERT(a_side_align, clk, rst_n, !hdv_vld || (h_side == ss_d[LAG]),
        "divider side data out of step")
    `HBA_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_data), "stalled result changed")
endmodule

// ----- hw/rtl/hba_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
// Does not depend on hba_pkg; its widths come from the caller's parameters.
module hba_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 11,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);
    logic [NUM_W:0]    vld_reg;
    logic [NUM_W-1:0]  q_reg [NUM_W+1];
    logic [DEN_W-1:0]  rem_reg [NUM_W+1];
    logic [DEN_W-1:0]  d_reg [NUM_W+1];
    logic [NUM_W-1:0]  n_reg [NUM_W+1];
    logic [SIDE_W-1:0] s_reg [NUM_W+1];

    always_comb
    begin
        vld_reg[0] = in_vld;
        q_reg[0] = '0;
        rem_reg[0] = '0;
        d_reg[0] = den;
        n_reg[0] = num;
        s_reg[0] = side_in;
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_st
        logic [DEN_W:0] trial;
        assign trial = {rem_reg[i], n_reg[i][NUM_W-1-i]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[i+1] <= d_reg[i];
                n_reg[i+1] <= n_reg[i];
                s_reg[i+1] <= s_reg[i];
                if (trial >= {1'b0, d_reg[i]})
                begin
                    rem_reg[i+1] <= DEN_W'(trial - {1'b0, d_reg[i]});
                    q_reg[i+1] <= q_reg[i] | (NUM_W'(1) << (NUM_W-1-i));
                end
                else
                begin
                    rem_reg[i+1] <= DEN_W'(trial);
                    q_reg[i+1] <= q_reg[i];
                end
            end
        end
    end

    assign out_vld = vld_reg[NUM_W];
    assign quo = q_reg[NUM_W];
    assign side_out = s_reg[NUM_W];
endmodule
